/* rtl/tls_sni_extractor_unit_assert.svh */
// Assertion macros shared by the extractor modules.
`ifndef TLS_SNI_EXTRACTOR_UNIT_ASSERT_SVH
`define TLS_SNI_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define TSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define TSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tse_pkg.sv */
package tse_pkg;

  localparam int SKIP_W = 17;

  localparam logic [SKIP_W-1:0] RECORD_BYTES  = 17'd5;
  localparam logic [SKIP_W-1:0] HS_BYTES      = 17'd4;
  localparam logic [SKIP_W-1:0] RANDOM_BYTES  = 17'd34;
  localparam logic [SKIP_W-1:0] LEN1_BYTES    = 17'd1;
  localparam logic [SKIP_W-1:0] LEN2_BYTES    = 17'd2;
  localparam logic [SKIP_W-1:0] EXT_HDR_BYTES = 17'd4;
  localparam logic [SKIP_W-1:0] SNI_PRE_BYTES = 17'd3;
  localparam logic [15:0]       SNI_TYPE      = 16'h0000;
  localparam logic [16:0]       CAPACITY_RST  = 17'd256;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_NO_SNI   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [15:0] {
    PH_REC      = 16'h0001,
    PH_HS       = 16'h0002,
    PH_RAND     = 16'h0004,
    PH_SESS_LEN = 16'h0008,
    PH_SESS     = 16'h0010,
    PH_CIPH_LEN = 16'h0020,
    PH_CIPH     = 16'h0040,
    PH_COMP_LEN = 16'h0080,
    PH_COMP     = 16'h0100,
    PH_EXT_LEN  = 16'h0200,
    PH_HDR      = 16'h0400,
    PH_EXT_SKIP = 16'h0800,
    PH_SNI_PRE  = 16'h1000,
    PH_NLEN     = 16'h2000,
    PH_NAME     = 16'h4000,
    PH_DONE     = 16'h8000
  } phase_t;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  name_byte;
    logic [1:0]  status;
    logic [15:0] name_length;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

/* rtl/tse_parser.sv */
`include "tls_sni_extractor_unit_assert.svh"

module tse_parser #(
  parameter int POSITION_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last,
  input  logic [16:0]           name_capacity,
  output tse_pkg::result_pair_t push
);
  import tse_pkg::*;

  localparam int P = POSITION_BITS;
  localparam logic [P-1:0] POS_MAX = '1;
  localparam logic [P:0]   HDR_LEN = (P+1)'(4);

  phase_t            phase, phase_next;
  logic [P-1:0]      position, position_next;
  logic [SKIP_W-1:0] skip_remaining, skip_remaining_next;
  logic [P-1:0]      extensions_end, extensions_end_next;
  logic [7:0]        high_byte_latch, high_byte_latch_next;
  logic [15:0]       extension_type, extension_type_next;
  logic [15:0]       declared_name_length, declared_name_length_next;
  logic [15:0]       name_bytes_left, name_bytes_left_next;

  logic [P-1:0]      pos_inc;
  logic [SKIP_W-1:0] skip_dec;
  logic [15:0]       word;
  logic [15:0]       left_dec;
  logic [P:0]        ext_sum;
  logic [P-1:0]      ext_sat;
  logic [P:0]        hdr_reach;
  logic              hdr_fail_cur, hdr_fail_new;
  logic              byte_vld, pend_vld;
  logic [1:0]        pend_status;
  logic [15:0]       verdict_len;
  result_t           byte_res, verdict_res;

  assign pos_inc      = (position == POS_MAX) ? position : position + 1'b1;
  assign skip_dec     = (skip_remaining == '0) ? skip_remaining : skip_remaining - 1'b1;
  assign left_dec     = (name_bytes_left == '0) ? name_bytes_left : name_bytes_left - 1'b1;
  assign word         = {high_byte_latch, data_byte};
  assign ext_sum      = {1'b0, pos_inc} + {{(P+1-16){1'b0}}, word};
  assign ext_sat      = ext_sum[P] ? POS_MAX : ext_sum[P-1:0];
  assign hdr_reach    = {1'b0, pos_inc} + HDR_LEN;
  assign hdr_fail_cur = hdr_reach > {1'b0, extensions_end};
  assign hdr_fail_new = hdr_reach > {1'b0, ext_sat};

  always_comb begin
    phase_next                = phase;
    position_next             = position;
    skip_remaining_next       = skip_remaining;
    extensions_end_next       = extensions_end;
    high_byte_latch_next      = high_byte_latch;
    extension_type_next       = extension_type;
    declared_name_length_next = declared_name_length;
    name_bytes_left_next      = name_bytes_left;
    byte_vld                  = 1'b0;
    pend_vld                  = 1'b0;
    pend_status               = ST_FOUND;
    verdict_len               = '0;

    if (accept && (phase != PH_DONE)) begin
      position_next = pos_inc;
      unique case (phase) inside
        PH_REC, PH_HS, PH_RAND, PH_SESS, PH_CIPH, PH_COMP, PH_EXT_SKIP, PH_SNI_PRE: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            case (phase)
              PH_REC: begin
                phase_next          = PH_HS;
                skip_remaining_next = HS_BYTES;
              end
              PH_HS: begin
                phase_next          = PH_RAND;
                skip_remaining_next = RANDOM_BYTES;
              end
              PH_RAND: begin
                phase_next          = PH_SESS_LEN;
                skip_remaining_next = LEN1_BYTES;
              end
              PH_SESS: begin
                phase_next          = PH_CIPH_LEN;
                skip_remaining_next = LEN2_BYTES;
              end
              PH_CIPH: begin
                phase_next          = PH_COMP_LEN;
                skip_remaining_next = LEN1_BYTES;
              end
              PH_COMP: begin
                phase_next          = PH_EXT_LEN;
                skip_remaining_next = LEN2_BYTES;
              end
              PH_EXT_SKIP: begin
                phase_next          = PH_HDR;
                skip_remaining_next = EXT_HDR_BYTES;
                if (hdr_fail_cur) begin
                  pend_vld    = 1'b1;
                  pend_status = ST_NO_SNI;
                end
              end
              default: begin
                phase_next          = PH_NLEN;
                skip_remaining_next = LEN2_BYTES;
              end
            endcase
          end
        end
        PH_SESS_LEN: begin
          if (data_byte != '0) begin
            phase_next          = PH_SESS;
            skip_remaining_next = {9'b0, data_byte};
          end else begin
            phase_next          = PH_CIPH_LEN;
            skip_remaining_next = LEN2_BYTES;
          end
        end
        PH_COMP_LEN: begin
          if (data_byte != '0) begin
            phase_next          = PH_COMP;
            skip_remaining_next = {9'b0, data_byte};
          end else begin
            phase_next          = PH_EXT_LEN;
            skip_remaining_next = LEN2_BYTES;
          end
        end
        PH_CIPH_LEN, PH_EXT_LEN, PH_NLEN: begin
          if (skip_remaining >= LEN2_BYTES) begin
            high_byte_latch_next = data_byte;
            skip_remaining_next  = LEN1_BYTES;
          end else begin
            case (phase)
              PH_CIPH_LEN: begin
                if (word != '0) begin
                  phase_next          = PH_CIPH;
                  skip_remaining_next = {1'b0, word};
                end else begin
                  phase_next          = PH_COMP_LEN;
                  skip_remaining_next = LEN1_BYTES;
                end
              end
              PH_EXT_LEN: begin
                extensions_end_next = ext_sat;
                phase_next          = PH_HDR;
                skip_remaining_next = EXT_HDR_BYTES;
                if (hdr_fail_new) begin
                  pend_vld    = 1'b1;
                  pend_status = ST_NO_SNI;
                end
              end
              default: begin
                declared_name_length_next = word;
                if ({1'b0, word} >= name_capacity) begin
                  pend_vld    = 1'b1;
                  pend_status = ST_TOO_LONG;
                end else if (word == '0) begin
                  pend_vld    = 1'b1;
                  pend_status = ST_FOUND;
                end else begin
                  phase_next           = PH_NAME;
                  name_bytes_left_next = word;
                end
              end
            endcase
          end
        end
        PH_HDR: begin
          if ((skip_remaining == 17'd4) || (skip_remaining == 17'd2)) begin
            high_byte_latch_next = data_byte;
            skip_remaining_next  = skip_dec;
          end else if (skip_remaining == 17'd3) begin
            extension_type_next = word;
            skip_remaining_next = LEN2_BYTES;
          end else if (extension_type == SNI_TYPE) begin
            phase_next          = PH_SNI_PRE;
            skip_remaining_next = SNI_PRE_BYTES;
          end else if (word != '0) begin
            phase_next          = PH_EXT_SKIP;
            skip_remaining_next = {1'b0, word};
          end else begin
            skip_remaining_next = EXT_HDR_BYTES;
            if (hdr_fail_cur) begin
              pend_vld    = 1'b1;
              pend_status = ST_NO_SNI;
            end
          end
        end
        PH_NAME: begin
          byte_vld             = 1'b1;
          name_bytes_left_next = left_dec;
          if (left_dec == '0) begin
            pend_vld    = 1'b1;
            pend_status = ST_FOUND;
          end
        end
        default: begin
        end
      endcase

      if (!pend_vld && last) begin
        pend_vld    = 1'b1;
        pend_status = ST_SHORT;
      end
      if (pend_vld) begin
        phase_next = PH_DONE;
      end
      verdict_len = (pend_status == ST_FOUND) ? declared_name_length_next : '0;
    end

    if (accept && last) begin
      phase_next                = PH_REC;
      position_next             = '0;
      skip_remaining_next       = RECORD_BYTES;
      extensions_end_next       = '0;
      high_byte_latch_next      = '0;
      extension_type_next       = '0;
      declared_name_length_next = '0;
      name_bytes_left_next      = '0;
    end
  end

  always_comb begin
    byte_res    = '{is_verdict: 1'b0, name_byte: data_byte, status: ST_FOUND,
                    name_length: 16'd0};
    verdict_res = '{is_verdict: 1'b1, name_byte: 8'd0, status: pend_status,
                    name_length: verdict_len};
    push.second = verdict_res;
    if (byte_vld) begin
      push.first = byte_res;
      push.count = pend_vld ? 2'd2 : 2'd1;
    end else begin
      push.first = verdict_res;
      push.count = pend_vld ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_REC;
      position             <= '0;
      skip_remaining       <= RECORD_BYTES;
      extensions_end       <= '0;
      high_byte_latch      <= '0;
      extension_type       <= '0;
      declared_name_length <= '0;
      name_bytes_left      <= '0;
    end else begin
      phase                <= phase_next;
      position             <= position_next;
      skip_remaining       <= skip_remaining_next;
      extensions_end       <= extensions_end_next;
      high_byte_latch      <= high_byte_latch_next;
      extension_type       <= extension_type_next;
      declared_name_length <= declared_name_length_next;
      name_bytes_left      <= name_bytes_left_next;
    end
  end

  `TSE_ASSERT_NOW(a_done_silent, accept && (phase == PH_DONE), push.count == 2'd0, "result after verdict")
  `TSE_ASSERT_NEXT(a_run_restart, accept && last, (phase == PH_REC) && (position == '0), "no restart after last")
  `TSE_ASSERT_NOW(a_pair_order, push.count == 2'd2, !push.first.is_verdict && push.second.is_verdict, "bad pair order")

endmodule

/* rtl/tse_out_queue.sv */
`include "tls_sni_extractor_unit_assert.svh"

module tse_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  tse_pkg::result_pair_t push,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tse_pkg::result_t      out_item
);
  import tse_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  result_t            entries [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_hi;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= CNT_W'(QDEPTH - 2));
  assign wr_ptr_hi = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_hi] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  `TSE_ASSERT_NOW(a_no_overflow, push.count != 2'd0, count <= CNT_W'(QDEPTH - 2), "queue overflow")
  `TSE_ASSERT_NEXT(a_empty_stays, (count == '0) && (push.count == 2'd0), count == '0, "phantom entry")
  `TSE_ASSERT_NEXT(a_hold_head, out_valid && !out_ready && (push.count == 2'd0), count == $past(count), "stalled head lost")

endmodule

/* rtl/tls_sni_extractor_unit.sv */
// Results are queued: one is offered on the master side no earlier than the cycle after
// its byte is taken, and a verdict from the same byte as a name byte waits behind it.
// Throughput: one byte per cycle while the master side keeps up; the slave side
// holds only while more than two results wait in the result queue.
// Reset: synchronous, active high; clears the parser and result queue and sets
// name_capacity to 256. No clearing pass.
module tls_sni_extractor_unit #(
  parameter int POSITION_BITS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] name_byte, [9:8] status, [25:10] name_length
  output logic        m_axis_tuser    // [0] is_verdict
);
  import tse_pkg::*;

  logic [16:0]  capacity;
  logic         accept;
  result_pair_t push;
  result_t      out_item;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  tse_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_axis_tdata),
    .last         (s_axis_tlast),
    .name_capacity(capacity),
    .push         (push)
  );

  tse_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_item (out_item)
  );

  assign m_axis_tdata = {6'b0, out_item.name_length, out_item.status, out_item.name_byte};
  assign m_axis_tuser = out_item.is_verdict;

endmodule

/* bench/tb_tls_sni_extractor_unit.sv */
module tb_tls_sni_extractor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tse_pkg::*;

  localparam int POS_BITS = 18;
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef enum int {NAME_EMPTY, NAME_SHORT, NAME_HUGE} name_mode_t;
  typedef enum int {
    AREA_EXACT, AREA_WIDE, AREA_CUT, AREA_HDR_FITS, AREA_HDR_MISSES, AREA_ANY
  } area_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  tls_sni_extractor_unit #(
    .POSITION_BITS(POS_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  stream_byte_t byte_stream[$];
  result_t      sni_results_due[$];

  logic [16:0]         name_cap;
  phase_t              walk_phase;
  logic [POS_BITS-1:0] byte_pos;
  logic [16:0]         bytes_to_skip;
  logic [POS_BITS-1:0] area_end;
  logic [7:0]          len_high;
  logic [15:0]         ext_kind;
  logic [15:0]         declared_len;
  logic [15:0]         name_left;
  bit                  run_closed;
  int                  verdict_code;

  int  mismatches = 0;
  int  runs_queued = 0;
  int  bytes_queued = 0;
  int  settings_used = 1;
  int  name_bytes_seen = 0;
  int  verdicts_seen[4] = '{0, 0, 0, 0};
  bit  s_hs = 1'b0;
  int  send_gap = 0;
  int  tx_calm = 0;
  int  stall_left = 0;
  int  rx_calm = 0;

  function automatic void clear_walk();
    walk_phase    = PH_REC;
    byte_pos      = '0;
    bytes_to_skip = RECORD_BYTES;
    area_end      = '0;
    len_high      = '0;
    ext_kind      = '0;
    declared_len  = '0;
    name_left     = '0;
    run_closed    = 1'b0;
  endfunction

  // Zero-length fields fall through to the next phase within the same byte.
  function automatic void enter_phase(phase_t p, logic [16:0] n);
    bit busy;
    busy = 1'b1;
    while (busy) begin
      walk_phase    = p;
      bytes_to_skip = n;
      if (p == PH_HDR) begin
        if ({1'b0, byte_pos} + 4 > {1'b0, area_end}) begin
          verdict_code = int'(ST_NO_SNI);
        end else begin
          bytes_to_skip = EXT_HDR_BYTES;
        end
        busy = 1'b0;
      end else if (n != 0) begin
        busy = 1'b0;
      end else begin
        case (p)
          PH_REC: begin
            p = PH_HS;
            n = HS_BYTES;
          end
          PH_HS: begin
            p = PH_RAND;
            n = RANDOM_BYTES;
          end
          PH_RAND: begin
            p = PH_SESS_LEN;
            n = LEN1_BYTES;
          end
          PH_SESS: begin
            p = PH_CIPH_LEN;
            n = LEN2_BYTES;
          end
          PH_CIPH: begin
            p = PH_COMP_LEN;
            n = LEN1_BYTES;
          end
          PH_COMP: begin
            p = PH_EXT_LEN;
            n = LEN2_BYTES;
          end
          PH_EXT_SKIP: begin
            p = PH_HDR;
            n = EXT_HDR_BYTES;
          end
          default: busy = 1'b0;
        endcase
      end
    end
  endfunction

  function automatic void parse_client_byte(logic [7:0] b, logic lst);
    logic [15:0]       v;
    logic [POS_BITS:0] e;
    result_t           r;
    verdict_code = -1;
    if (!run_closed) begin
      if (byte_pos < POS_LIMIT) byte_pos++;
      v = {len_high, b};
      case (walk_phase)
        PH_REC, PH_HS, PH_RAND, PH_SESS, PH_CIPH, PH_COMP, PH_EXT_SKIP: begin
          if (bytes_to_skip != 0) bytes_to_skip--;
          if (bytes_to_skip == 0) enter_phase(walk_phase, '0);
        end
        PH_SNI_PRE: begin
          if (bytes_to_skip != 0) bytes_to_skip--;
          if (bytes_to_skip == 0) enter_phase(PH_NLEN, LEN2_BYTES);
        end
        PH_SESS_LEN: enter_phase(PH_SESS, {9'd0, b});
        PH_COMP_LEN: enter_phase(PH_COMP, {9'd0, b});
        PH_CIPH_LEN, PH_EXT_LEN, PH_NLEN: begin
          if (bytes_to_skip >= 2) begin
            len_high      = b;
            bytes_to_skip = LEN1_BYTES;
          end else if (walk_phase == PH_CIPH_LEN) begin
            enter_phase(PH_CIPH, {1'b0, v});
          end else if (walk_phase == PH_EXT_LEN) begin
            e        = {1'b0, byte_pos} + (POS_BITS+1)'(v);
            area_end = (e > {1'b0, POS_LIMIT}) ? POS_LIMIT : e[POS_BITS-1:0];
            enter_phase(PH_HDR, EXT_HDR_BYTES);
          end else begin
            declared_len = v;
            if ({1'b0, v} >= name_cap) begin
              verdict_code = int'(ST_TOO_LONG);
            end else if (v == 0) begin
              verdict_code = int'(ST_FOUND);
            end else begin
              walk_phase = PH_NAME;
              name_left  = v;
            end
          end
        end
        PH_HDR: begin
          if (bytes_to_skip == 4 || bytes_to_skip == 2) begin
            len_high = b;
            bytes_to_skip--;
          end else if (bytes_to_skip == 3) begin
            ext_kind      = v;
            bytes_to_skip = 2;
          end else if (ext_kind == SNI_TYPE) begin
            enter_phase(PH_SNI_PRE, SNI_PRE_BYTES);
          end else begin
            enter_phase(PH_EXT_SKIP, {1'b0, v});
          end
        end
        PH_NAME: begin
          r           = '0;
          r.name_byte = b;
          sni_results_due.push_back(r);
          if (name_left != 0) name_left--;
          if (name_left == 0) verdict_code = int'(ST_FOUND);
        end
        default: ;
      endcase
      if (verdict_code < 0 && lst) verdict_code = int'(ST_SHORT);
      if (verdict_code >= 0) begin
        r             = '0;
        r.is_verdict  = 1'b1;
        r.status      = 2'(verdict_code);
        r.name_length = (verdict_code == int'(ST_FOUND)) ? declared_len : 16'd0;
        sni_results_due.push_back(r);
        run_closed = 1'b1;
        walk_phase = PH_DONE;
      end
    end
    if (lst) clear_walk();
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    result_t got;
    got.is_verdict  = m_axis_tuser;
    got.name_byte   = m_axis_tdata[7:0];
    got.status      = m_axis_tdata[9:8];
    got.name_length = m_axis_tdata[25:10];
    if (sni_results_due.size() == 0) begin
      $display("%0t ns: expected nothing, got tdata %h tuser %b",
               $time, m_axis_tdata, m_axis_tuser);
      mismatches++;
    end else begin
      want = sni_results_due.pop_front();
      compare_field("is_verdict", want.is_verdict, got.is_verdict);
      compare_field("name_byte", want.name_byte, got.name_byte);
      compare_field("status", want.status, got.status);
      compare_field("name_length", want.name_length, got.name_length);
      if (got.is_verdict) verdicts_seen[got.status]++;
      else name_bytes_seen++;
    end
  endfunction

  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_bytes(logic [7:0] hb[$]);
    stream_byte_t sb;
    foreach (hb[i]) begin
      sb.data = hb[i];
      sb.last = (i == hb.size() - 1);
      byte_stream.push_back(sb);
    end
    bytes_queued += hb.size();
    runs_queued++;
  endfunction

  function automatic void queue_hello(bit with_name, name_mode_t name_mode,
                                     area_mode_t area_mode, bit cut);
    logic [7:0]  hb[$];
    logic [7:0]  area[$];
    logic [15:0] code;
    logic [15:0] nl;
    int          n;
    int          sni_at;
    int          area_len;
    repeat (43) hb.push_back(8'($urandom));
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    hb.push_back(8'(n));
    repeat (n) hb.push_back(8'($urandom));
    n = ($urandom_range(0, 3) == 0) ? 0 : 2 * $urandom_range(1, 3);
    hb.push_back(8'h00);
    hb.push_back(8'(n));
    repeat (n) hb.push_back(8'($urandom));
    n = $urandom_range(0, 2);
    hb.push_back(8'(n));
    repeat (n) hb.push_back(8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      code = $urandom_range(0, 1) ? 16'(1 << $urandom_range(0, 15))
                                  : 16'($urandom_range(1, 65535));
      n = $urandom_range(0, 5);
      area.push_back(code[15:8]);
      area.push_back(code[7:0]);
      area.push_back(8'h00);
      area.push_back(8'(n));
      repeat (n) area.push_back(8'($urandom));
    end
    sni_at = area.size();
    if (with_name) begin
      case (name_mode)
        NAME_EMPTY: nl = '0;
        NAME_SHORT: nl = 16'($urandom_range(1, 12));
        default:    nl = 16'($urandom_range(13, 65535));
      endcase
      area.push_back(SNI_TYPE[15:8]);
      area.push_back(SNI_TYPE[7:0]);
      repeat (5) area.push_back(8'($urandom));
      area.push_back(nl[15:8]);
      area.push_back(nl[7:0]);
      repeat ((nl > 12) ? $urandom_range(0, 4) : int'(nl)) area.push_back(8'($urandom));
    end
    case (area_mode)
      AREA_WIDE:       area_len = area.size() + $urandom_range(1, 8);
      AREA_CUT:        area_len = $urandom_range(0, area.size());
      AREA_HDR_FITS:   area_len = sni_at + 4;
      AREA_HDR_MISSES: area_len = sni_at + 3;
      AREA_ANY:        area_len = $urandom_range(0, 65535);
      default:         area_len = area.size();
    endcase
    hb.push_back(8'(area_len >> 8));
    hb.push_back(8'(area_len));
    foreach (area[i]) hb.push_back(area[i]);
    repeat ($urandom_range(0, 3)) hb.push_back(8'($urandom));
    if (cut) begin
      n = $urandom_range(1, hb.size());
      while (hb.size() > n) hb.delete(hb.size() - 1);
    end
    queue_bytes(hb);
  endfunction

  function automatic void queue_random_run();
    logic [7:0] hb[$];
    int         r;
    name_mode_t nm;
    area_mode_t am;
    r  = $urandom_range(0, 9);
    nm = (r == 0) ? NAME_EMPTY : (r < 8) ? NAME_SHORT : NAME_HUGE;
    am = $urandom_range(0, 1) ? AREA_EXACT : area_mode_t'($urandom_range(1, 5));
    r  = $urandom_range(0, 99);
    if (r < 55) begin
      queue_hello(1'b1, nm, am, 1'b0);
    end else if (r < 70) begin
      queue_hello(1'b1, nm, am, 1'b1);
    end else if (r < 85) begin
      queue_hello(1'b0, nm, am, $urandom_range(0, 3) == 0);
    end else begin
      repeat ($urandom_range(1, 40)) hb.push_back(8'($urandom));
      queue_bytes(hb);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_hs <= 1'b0;
    end else begin
      s_hs <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) parse_client_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || s_hs)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_stream.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_stream[0].data;
        s_axis_tlast  <= byte_stream[0].last;
        byte_stream.delete(0);
        send_gap = pick_pause(tx_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_pause(rx_calm);
      end
    end
  end

  task automatic wait_drained();
    int n;
    n = 0;
    while ((byte_stream.size() != 0 || s_axis_tvalid || sni_results_due.size() != 0)
           && n < 400000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [16:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    name_cap  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase();
    int start;
    @(posedge clk);
    start = bytes_queued;
    while (bytes_queued - start < 20) queue_random_run();
    wait_drained();
  endtask

  initial begin
    logic [7:0] lone[3];
    stream_byte_t sb;
    lone = '{8'h00, 8'hFF, 8'hA5};
    name_cap = CAPACITY_RST;
    clear_walk();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    @(posedge clk);
    foreach (lone[i]) begin
      sb.data = lone[i];
      sb.last = 1'b1;
      byte_stream.push_back(sb);
      bytes_queued++;
      runs_queued++;
    end
    queue_hello(1'b1, NAME_EMPTY, AREA_EXACT, 1'b0);
    queue_hello(1'b1, NAME_SHORT, AREA_HDR_FITS, 1'b0);
    queue_hello(1'b1, NAME_SHORT, AREA_HDR_MISSES, 1'b0);
    queue_hello(1'b0, NAME_SHORT, AREA_EXACT, 1'b0);
    queue_hello(1'b1, NAME_HUGE, AREA_EXACT, 1'b0);
    queue_hello(1'b1, NAME_SHORT, AREA_EXACT, 1'b1);
    wait_drained();

    run_random_phase();
    set_capacity(17'd1);
    run_random_phase();
    set_capacity(17'h10000);
    run_random_phase();
    set_capacity(17'd5);
    run_random_phase();
    set_capacity(17'($urandom_range(1, 65536)));
    run_random_phase();

    if (sni_results_due.size() != 0) begin
      $display("%0t ns: %0d results never arrived, next expected %h",
               $time, sni_results_due.size(), sni_results_due[0]);
      mismatches += sni_results_due.size();
    end
    $display("Covered %0d runs (%0d bytes) over %0d name capacity settings, %0d name bytes",
             runs_queued, bytes_queued, settings_used, name_bytes_seen);
    $display("Verdicts: %0d found, %0d cut short, %0d without a name, %0d over capacity",
             verdicts_seen[ST_FOUND], verdicts_seen[ST_SHORT], verdicts_seen[ST_NO_SNI],
             verdicts_seen[ST_TOO_LONG]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Timed out with %0d results outstanding", sni_results_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tse_pkg.sv
rtl/tse_parser.sv
rtl/tse_out_queue.sv
rtl/tls_sni_extractor_unit.sv
bench/tb_tls_sni_extractor_unit.sv
